### rtl/core/lcrr_pkg.sv
// ----------------------------------------------------------------------------
// lcrr_pkg
// Shared types and constants of the least-connections / round-robin balancer.
// ----------------------------------------------------------------------------
package lcrr_pkg;

    // item field widths
    localparam int FUNC_W   = 1;
    localparam int SLOT_W   = 3;
    localparam int DELTA_W  = 16;
    localparam int SCOUNT_W = 16;

    // configuration registers
    localparam int MASK_W    = 8;
    localparam int ROT_W     = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_POLICY_MODE   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ENABLED_SLOTS = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_SELECT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

    localparam logic POLICY_ROUND_ROBIN = 1'b0;
    localparam logic POLICY_LEAST_CONN  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] idx;
        logic [APB_DW-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        logic              policy_mode;
        logic [MASK_W-1:0] enabled_slots;
    } t_cfg_regs;

endpackage

### rtl/core/lcrr_req_if.sv
// ----------------------------------------------------------------------------
// lcrr_req_if
// Request channel: select or count update item.
// ----------------------------------------------------------------------------
interface lcrr_req_if;
    logic                                valid;
    logic                                ready;
    logic [lcrr_pkg::FUNC_W-1:0]         func;
    logic [lcrr_pkg::SLOT_W-1:0]         slot_index;
    logic signed [lcrr_pkg::DELTA_W-1:0] count_delta;

    modport source (output valid, output func, output slot_index, output count_delta,
                    input ready);
    modport sink   (input valid, input func, input slot_index, input count_delta,
                    output ready);
endinterface

### rtl/core/lcrr_rsp_if.sv
// ----------------------------------------------------------------------------
// lcrr_rsp_if
// Response channel: chosen slot, error flag and slot count.
// ----------------------------------------------------------------------------
interface lcrr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [lcrr_pkg::SLOT_W-1:0]    chosen_slot;
    logic                           error_flag;
    logic [lcrr_pkg::SCOUNT_W-1:0]  slot_count;

    modport source (output valid, output chosen_slot, output error_flag, output slot_count,
                    input ready);
    modport sink   (input valid, input chosen_slot, input error_flag, input slot_count,
                    output ready);
endinterface

### rtl/core/lcrr_ctrl.sv
// ----------------------------------------------------------------------------
// lcrr_ctrl
// Sequencer: accepts an item, runs the slot scan for a select, then hands off the result.
// ----------------------------------------------------------------------------
module lcrr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [lcrr_pkg::FUNC_W-1:0] i_in_func,
    output logic                        o_in_ready,
    input  lcrr_pkg::t_dp_stat          i_stat,
    output lcrr_pkg::t_dp_cmd           o_cmd
);

    lcrr_pkg::t_state r_state;
    lcrr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcrr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcrr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    // updates need no scan
                    n_state = (i_in_func == lcrr_pkg::FUNC_UPDATE) ? lcrr_pkg::S_FINISH
                                                                   : lcrr_pkg::S_SCAN;
                end
            end
            lcrr_pkg::S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = lcrr_pkg::S_FINISH;
                end
            end
            lcrr_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = lcrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcrr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            lcrr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            lcrr_pkg::S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            lcrr_pkg::S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/lcrr_datapath.sv
// ----------------------------------------------------------------------------
// lcrr_datapath
// Slot counts, rotation state, one-slot-per-cycle scan and result register.
// ----------------------------------------------------------------------------
module lcrr_datapath #(
    parameter int SLOTS       = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lcrr_pkg::t_dp_cmd                   i_cmd,
    output lcrr_pkg::t_dp_stat                  o_stat,
    input  lcrr_pkg::t_cfg_wr                   i_cfg_wr,
    output lcrr_pkg::t_cfg_regs                 o_cfg_regs,
    input  logic [lcrr_pkg::FUNC_W-1:0]         i_func,
    input  logic [lcrr_pkg::SLOT_W-1:0]         i_slot_index,
    input  logic signed [lcrr_pkg::DELTA_W-1:0] i_count_delta,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [lcrr_pkg::SLOT_W-1:0]         o_chosen_slot,
    output logic                                o_error_flag,
    output logic [lcrr_pkg::SCOUNT_W-1:0]       o_slot_count
);

    // only the first eight slots can ever be enabled
    localparam int LANES = (SLOTS < lcrr_pkg::MASK_W) ? SLOTS : lcrr_pkg::MASK_W;
    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NUM_W = $clog2(LANES + 1);
    localparam int EXT_W = (COUNT_WIDTH > lcrr_pkg::SCOUNT_W) ? COUNT_WIDTH
                                                               : lcrr_pkg::SCOUNT_W;
    localparam int SUM_W = EXT_W + 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANES - 1);

    logic                                r_policy;
    logic [lcrr_pkg::MASK_W-1:0]         r_mask;
    logic [COUNT_WIDTH-1:0]              r_cnt [LANES];
    logic [IDX_W-1:0]                    r_res [LANES];
    logic [lcrr_pkg::ROT_W-1:0]          r_rot;
    logic                                r_out_valid;

    logic [lcrr_pkg::FUNC_W-1:0]         r_func;
    logic [lcrr_pkg::SLOT_W-1:0]         r_slot;
    logic signed [lcrr_pkg::DELTA_W-1:0] r_delta;
    logic [IDX_W-1:0]                    r_idx;
    logic [IDX_W-1:0]                    r_seen;
    logic [IDX_W-1:0]                    r_pick;
    logic                                r_have;
    logic [COUNT_WIDTH-1:0]              r_best;
    logic [lcrr_pkg::SLOT_W-1:0]         r_out_slot;
    logic                                r_out_err;
    logic [lcrr_pkg::SCOUNT_W-1:0]       r_out_count;

    logic [LANES-1:0]                    w_en;
    logic [NUM_W-1:0]                    w_num;
    logic [IDX_W-1:0]                    w_k;
    logic                                w_is_upd;
    logic                                w_upd_en;
    logic [IDX_W-1:0]                    w_rd_addr;
    logic [COUNT_WIDTH-1:0]              w_rd;
    logic signed [SUM_W-1:0]             w_sum;
    logic [COUNT_WIDTH-1:0]              w_new;
    logic [EXT_W-1:0]                    w_new_ext;
    logic [EXT_W-1:0]                    w_rd_ext;
    logic                                w_scan_en;
    logic                                w_rr_hit;
    logic                                w_lc_hit;
    logic                                w_none;
    logic                                w_advance;
    logic                                w_out_free;
    logic                                w_cfg_mask;

    assign w_en = r_mask[LANES-1:0];

    always_comb begin
        w_num = '0;
        for (int i = 0; i < LANES; i++) begin
            w_num = w_num + NUM_W'(w_en[i]);
        end
    end

    // rotation counter modulo the enabled count, kept as one residue per count
    assign w_k  = (w_num == '0) ? '0 : r_res[IDX_W'(w_num - NUM_W'(1))];
    assign w_none = (w_num == '0);

    assign w_is_upd  = (r_func == lcrr_pkg::FUNC_UPDATE);
    assign w_upd_en  = (int'(r_slot) < LANES) && r_mask[r_slot];
    assign w_rd_addr = w_is_upd ? r_slot[IDX_W-1:0] : (i_cmd.finish ? r_pick : r_idx);
    assign w_rd      = r_cnt[w_rd_addr];
    assign w_rd_ext  = EXT_W'(w_rd);

    // clamp at zero and saturate at all ones
    assign w_sum = $signed({{(SUM_W-COUNT_WIDTH){1'b0}}, w_rd})
                 + $signed({{(SUM_W-lcrr_pkg::DELTA_W){r_delta[lcrr_pkg::DELTA_W-1]}},
                            r_delta});

    always_comb begin
        if (w_sum[SUM_W-1]) begin
            w_new = '0;
        end else if (|w_sum[SUM_W-2:COUNT_WIDTH]) begin
            w_new = '1;
        end else begin
            w_new = w_sum[COUNT_WIDTH-1:0];
        end
    end

    assign w_new_ext = EXT_W'(w_new);

    assign w_scan_en = w_en[r_idx];
    assign w_rr_hit  = w_scan_en && !r_have && (r_seen == w_k);
    assign w_lc_hit  = w_scan_en && (!r_have || (w_rd < r_best));

    assign w_advance  = i_cmd.finish && !w_is_upd && !w_none
                        && (r_policy == lcrr_pkg::POLICY_ROUND_ROBIN);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_cfg_mask = i_cfg_wr.we && (i_cfg_wr.idx == lcrr_pkg::REG_ENABLED_SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= lcrr_pkg::POLICY_ROUND_ROBIN;
            r_mask      <= '0;
            r_rot       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_cnt[i] <= '0;
                r_res[i] <= '0;
            end
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.finish && w_is_upd && w_upd_en) begin
                r_cnt[r_slot[IDX_W-1:0]] <= w_new;
            end

            if (w_advance) begin
                r_rot <= r_rot + 1'b1;
                for (int j = 0; j < LANES; j++) begin
                    // counter wrap restarts every residue
                    if ((r_rot == '1) || (r_res[j] == IDX_W'(j))) begin
                        r_res[j] <= '0;
                    end else begin
                        r_res[j] <= r_res[j] + 1'b1;
                    end
                end
            end

            if (i_cfg_wr.we && (i_cfg_wr.idx == lcrr_pkg::REG_POLICY_MODE)) begin
                r_policy <= i_cfg_wr.data[0];
            end
            if (w_cfg_mask) begin
                r_mask <= i_cfg_wr.data[lcrr_pkg::MASK_W-1:0];
                // disabled slots restart from zero
                for (int i = 0; i < LANES; i++) begin
                    if (!i_cfg_wr.data[i]) begin
                        r_cnt[i] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_slot  <= i_slot_index;
            r_delta <= i_count_delta;
            r_idx   <= '0;
            r_seen  <= '0;
            r_pick  <= '0;
            r_have  <= 1'b0;
            r_best  <= '0;
        end else if (i_cmd.step) begin
            if (r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_policy == lcrr_pkg::POLICY_ROUND_ROBIN) begin
                if (w_rr_hit) begin
                    r_pick <= r_idx;
                    r_have <= 1'b1;
                end
                if (w_scan_en) begin
                    r_seen <= r_seen + 1'b1;
                end
            end else begin
                if (w_lc_hit) begin
                    r_pick <= r_idx;
                    r_have <= 1'b1;
                    r_best <= w_rd;
                end
            end
        end

        if (i_cmd.finish) begin
            if (w_is_upd) begin
                r_out_slot  <= r_slot;
                r_out_err   <= !w_upd_en;
                r_out_count <= w_upd_en ? w_new_ext[lcrr_pkg::SCOUNT_W-1:0] : '0;
            end else if (w_none) begin
                r_out_slot  <= '0;
                r_out_err   <= 1'b1;
                r_out_count <= '0;
            end else begin
                r_out_slot  <= lcrr_pkg::SLOT_W'(r_pick);
                r_out_err   <= 1'b0;
                r_out_count <= w_rd_ext[lcrr_pkg::SCOUNT_W-1:0];
            end
        end
    end

    assign o_stat.scan_last = (r_idx == LAST_IDX);
    assign o_stat.out_free  = w_out_free;

    assign o_cfg_regs.policy_mode   = r_policy;
    assign o_cfg_regs.enabled_slots = r_mask;

    assign o_out_valid   = r_out_valid;
    assign o_chosen_slot = r_out_slot;
    assign o_error_flag  = r_out_err;
    assign o_slot_count  = r_out_count;

endmodule

### rtl/core/least_conn_round_robin_balancer_core.sv
// ----------------------------------------------------------------------------
// least_conn_round_robin_balancer_core
// Server slot balancer: round-robin or least-connections select, count update.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  i_req     in         valid/ready        func, slot_index, count_delta
//  o_rsp     out        valid/ready        chosen_slot, error_flag, slot_count
//  apb       in/out     psel/penable       policy_mode @0x0, enabled_slots @0x4
//
//  a select item runs a scan of min(SLOTS,8) slots before its result: the scan
//  reads one slot count per cycle through a single read port
//  an update item needs no scan: one read-add-clamp-write of its slot
//  the next item can be taken in the cycle the result appears, even while it waits
//  a stalled result holds the sequencer in its last step
//  synchronous active-low reset; counts, rotation and registers clear to zero
// ----------------------------------------------------------------------------
module least_conn_round_robin_balancer_core #(
    parameter int SLOTS       = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lcrr_req_if.sink                      i_req,
    lcrr_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcrr_pkg::APB_AW-1:0]   paddr,
    input  logic [lcrr_pkg::APB_DW-1:0]   pwdata,
    output logic [lcrr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    lcrr_pkg::t_dp_cmd   w_cmd;
    lcrr_pkg::t_dp_stat  w_stat;
    lcrr_pkg::t_cfg_wr   w_cfg_wr;
    lcrr_pkg::t_cfg_regs w_cfg_regs;
    logic                w_in_ready;
    logic [lcrr_pkg::REG_IDX_W-1:0] w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[lcrr_pkg::APB_AW-1 -: lcrr_pkg::REG_IDX_W];

    assign w_cfg_wr.we   = psel && penable && pwrite;
    assign w_cfg_wr.idx  = w_reg_idx;
    assign w_cfg_wr.data = pwdata;

    always_comb begin
        unique case (w_reg_idx)
            lcrr_pkg::REG_POLICY_MODE: begin
                prdata = lcrr_pkg::APB_DW'(w_cfg_regs.policy_mode);
            end
            lcrr_pkg::REG_ENABLED_SLOTS: begin
                prdata = lcrr_pkg::APB_DW'(w_cfg_regs.enabled_slots);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign i_req.ready = w_in_ready;

    lcrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_func  (i_req.func),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lcrr_datapath #(
        .SLOTS       (SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_wr      (w_cfg_wr),
        .o_cfg_regs    (w_cfg_regs),
        .i_func        (i_req.func),
        .i_slot_index  (i_req.slot_index),
        .i_count_delta (i_req.count_delta),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_chosen_slot (o_rsp.chosen_slot),
        .o_error_flag  (o_rsp.error_flag),
        .o_slot_count  (o_rsp.slot_count)
    );

endmodule
